// ===== rtl/core/vcrb_pkg.sv =====
// Shared types and constants of the valid 2D convolution block.
package vcrb_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_IMAGE_COLS  = 3'd0;
	localparam logic [2:0] CFG_IMAGE_ROWS  = 3'd1;
	localparam logic [2:0] CFG_KERNEL_ROWS = 3'd2;
	localparam logic [2:0] CFG_KERNEL_COLS = 3'd3;
	localparam logic [2:0] CFG_BIAS_VALUE  = 3'd4;

	localparam logic OP_COEFF = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam int MAX_ROWS = 4096;

	typedef struct packed {
		logic               operation;
		logic [4:0]         coeff_index;
		logic signed [15:0] coeff_value;
		logic signed [15:0] pixel_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [11:0]        out_row;
		logic [9:0]         out_col;
		logic               last_output;
	} out_t;

	// position tag carried down the pipe with each result
	typedef struct packed {
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic        last_output;
	} meta_t;

endpackage

// ===== rtl/core/vcrb_cell.sv =====
// One window row: optional line bank, window taps, products and row sum.
module vcrb_cell import vcrb_pkg::*; #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_COLS   = 1024,
	parameter int COL_W      = 10,
	parameter bit HAS_LINE   = 1'b1,
	parameter int SUM_W      = 36
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          rd_en,
	input  logic [COL_W-1:0]              rd_addr,
	input  logic                          wr_en,
	input  logic [COL_W-1:0]              wr_addr,
	input  logic                          fwd_s1,
	input  logic [15:0]                   px_in,
	input  logic [MAX_KERNEL-1:0][15:0]   coef,
	output logic [15:0]                   line_out,
	output logic signed [SUM_W-1:0]       row_sum_s4
);

	logic [15:0]             win_q [MAX_KERNEL];
	logic signed [31:0]      prod_s3 [MAX_KERNEL];
	logic signed [SUM_W-1:0] sum_c;

	generate
		if (HAS_LINE) begin : g_line
			logic [15:0] mem [MAX_COLS];
			logic [15:0] rd_q;
			logic [15:0] fwd_q;

			// read-before-write; fwd_q covers a write to the same column
			always_ff @(posedge clk) begin
				if (wr_en) begin
					mem[wr_addr] <= px_in;
				end
				if (rd_en) begin
					rd_q  <= mem[rd_addr];
					fwd_q <= px_in;
				end
			end

			assign line_out = fwd_s1 ? fwd_q : rd_q;
		end else begin : g_noline
			assign line_out = '0;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int c = 0; c < MAX_KERNEL - 1; c++) begin
				win_q[c] <= win_q[c+1];
			end
			win_q[MAX_KERNEL-1] <= px_in;
		end
	end

	// taps outside the kernel carry a zero coefficient; their product is forced
	// to zero so line data not yet written never reaches the sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < MAX_KERNEL; c++) begin
				prod_s3[c] <= (coef[c] == 16'd0) ? 32'sd0 :
					$signed(win_q[c]) * $signed(coef[c]);
			end
			row_sum_s4 <= sum_c;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int c = 0; c < MAX_KERNEL; c++) begin
			sum_c = sum_c + {{(SUM_W-32){prod_s3[c][31]}}, prod_s3[c]};
		end
	end

endmodule

// ===== rtl/core/vcrb_skid.sv =====
// Two-entry result queue between the pipe and the output port.
module vcrb_skid import vcrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  out_t push_data,
	input  logic pop,
	output logic full,
	output logic valid,
	output out_t data
);

	out_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign data  = buf_q[rd_ptr_q];

endmodule

// ===== rtl/core/valid_conv2d_relu_bias_top.sv =====
// Top level of the streaming valid 2D convolution with ReLU and bias.
// Coefficient beats (operation 0) load the kernel; pixel beats (operation 1)
// arrive in raster order and each pixel that completes a kernel_rows x
// kernel_cols window yields one result beat: ReLU of the saturated window sum,
// then plus bias_value, saturated to 32 bits, tagged with its row and column in
// the valid plane and with last_output on the image's final result. One beat
// is taken per clock while in_stall is low. The datapath is a chain of
// MAX_KERNEL row cells: every cell but cell 0 owns one line bank of MAX_COLS
// pixels and hands the pixel it read from that bank to the cell below, so all
// banks are read and written once per pixel beat (the bank port sets the
// one-pixel-per-clock rate). A two-entry result queue sits at the output:
// in_stall rises only while two results are waiting. Line banks are not
// cleared after reset; the first kernel_rows-1 rows of each image fill them
// before any window reads them. The user must write configuration only while
// the block is idle; the block itself does not enforce it.
module valid_conv2d_relu_bias_top import vcrb_pkg::*; #(
	parameter int MAX_COLS   = 1024,
	parameter int MAX_KERNEL = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int KW    = $clog2(MAX_KERNEL + 1);
	localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;
	localparam int CIW   = (NCOEF > 1) ? $clog2(NCOEF) : 1;
	localparam int SUM_W = 32 + KW + 1;
	localparam int TOT_W = 32 + 2 * KW + 1;

	// configuration
	logic [10:0]        image_cols_q;
	logic [12:0]        image_rows_q;
	logic [2:0]         kernel_rows_q;
	logic [2:0]         kernel_cols_q;
	logic signed [31:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q  <= 11'd28;
			image_rows_q  <= 13'd28;
			kernel_rows_q <= 3'd3;
			kernel_cols_q <= 3'd3;
			bias_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_COLS:  image_cols_q  <= cfg_data[10:0];
				CFG_IMAGE_ROWS:  image_rows_q  <= cfg_data[12:0];
				CFG_KERNEL_ROWS: kernel_rows_q <= cfg_data[2:0];
				CFG_KERNEL_COLS: kernel_cols_q <= cfg_data[2:0];
				CFG_BIAS_VALUE:  bias_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped sizes
	logic [COL_W:0] cols_w;
	logic [12:0]    rows_w;
	logic [KW-1:0]  kr_w;
	logic [KW-1:0]  kc_w;

	always_comb begin
		if (image_cols_q == 11'd0) begin
			cols_w = (COL_W+1)'(1);
		end else if (image_cols_q > MAX_COLS) begin
			cols_w = (COL_W+1)'(MAX_COLS);
		end else begin
			cols_w = (COL_W+1)'(image_cols_q);
		end
		if (image_rows_q == 13'd0) begin
			rows_w = 13'd1;
		end else if (image_rows_q > MAX_ROWS) begin
			rows_w = 13'(MAX_ROWS);
		end else begin
			rows_w = image_rows_q;
		end
		if (kernel_rows_q == 3'd0) begin
			kr_w = KW'(1);
		end else if (kernel_rows_q > MAX_KERNEL) begin
			kr_w = KW'(MAX_KERNEL);
		end else begin
			kr_w = KW'(kernel_rows_q);
		end
		if (kernel_cols_q == 3'd0) begin
			kc_w = KW'(1);
		end else if (kernel_cols_q > MAX_KERNEL) begin
			kc_w = KW'(MAX_KERNEL);
		end else begin
			kc_w = KW'(kernel_cols_q);
		end
	end

	// pipe control: everything moves together unless the queue is full
	logic q_full;
	logic en;
	logic acc;
	logic pix_in;

	assign en       = !q_full;
	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;
	assign pix_in   = (in_data.operation == OP_PIXEL);

	// raster counters
	logic [COL_W-1:0] col_q;
	logic [11:0]      row_q;
	logic [COL_W:0]   col_p1;
	logic [12:0]      row_p1;
	logic             res_c;
	meta_t            meta_c;

	assign col_p1 = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_p1 = {1'b0, row_q} + 13'd1;

	always_comb begin
		res_c              = (row_p1 >= 13'(kr_w)) && (col_p1 >= (COL_W+1)'(kc_w));
		meta_c.out_row     = 12'(row_p1 - 13'(kr_w));
		meta_c.out_col     = 10'(col_p1 - (COL_W+1)'(kc_w));
		meta_c.last_output = (row_p1 >= rows_w) && (col_p1 >= cols_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc && pix_in) begin
			if (col_p1 >= cols_w) begin
				col_q <= '0;
				row_q <= (row_p1 >= rows_w) ? 12'd0 : row_p1[11:0];
			end else begin
				col_q <= col_p1[COL_W-1:0];
			end
		end
	end

	// stage 1: bank read data returns, window column formed
	logic             vld_s1, pix_s1, res_s1, fwd_s1;
	logic [COL_W-1:0] col_s1;
	logic [15:0]      pixel_s1;
	logic [4:0]       cidx_s1;
	logic [15:0]      cval_s1;
	meta_t            meta_s1;
	logic             res_s2, res_s3, res_s4, res_s5, res_s6;
	meta_t            meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			pix_s1 <= 1'b0;
			res_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			res_s2 <= 1'b0;
			res_s3 <= 1'b0;
			res_s4 <= 1'b0;
			res_s5 <= 1'b0;
			res_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			pix_s1 <= acc && pix_in;
			res_s1 <= acc && pix_in && res_c;
			// previous pixel writes the column being read this edge
			fwd_s1 <= pix_s1 && (col_s1 == col_q);
			res_s2 <= res_s1;
			res_s3 <= res_s2;
			res_s4 <= res_s3;
			res_s5 <= res_s4;
			res_s6 <= res_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1   <= col_q;
			pixel_s1 <= in_data.pixel_value;
			cidx_s1  <= in_data.coeff_index;
			cval_s1  <= in_data.coeff_value;
			meta_s1  <= meta_c;
			meta_s2  <= meta_s1;
			meta_s3  <= meta_s2;
			meta_s4  <= meta_s3;
			meta_s5  <= meta_s4;
			meta_s6  <= meta_s5;
		end
	end

	// coefficients: written as the load passes stage 1, in order with pixels
	logic [15:0] coeff_q [NCOEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (en && vld_s1 && !pix_s1) begin
			for (int i = 0; i < NCOEF; i++) begin
				if (32'(cidx_s1) == i) begin
					coeff_q[i] <= cval_s1;
				end
			end
		end
	end

	// kernel aligned to the bottom-right corner of the window
	logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][15:0] coef_al;

	always_comb begin
		int ro;
		int co;
		ro = MAX_KERNEL - int'(kr_w);
		co = MAX_KERNEL - int'(kc_w);
		for (int r = 0; r < MAX_KERNEL; r++) begin
			for (int c = 0; c < MAX_KERNEL; c++) begin
				coef_al[r][c] = '0;
				if (r >= ro && c >= co) begin
					coef_al[r][c] = coeff_q[CIW'((r - ro) * MAX_KERNEL + (c - co))];
				end
			end
		end
	end

	// cell chain, cell MAX_KERNEL-1 takes the new pixel
	logic [15:0]             px_in   [MAX_KERNEL];
	logic [15:0]             line_out[MAX_KERNEL];
	logic signed [SUM_W-1:0] row_sum [MAX_KERNEL];

	genvar gr;
	generate
		for (gr = 0; gr < MAX_KERNEL; gr++) begin : g_cell
			if (gr == MAX_KERNEL - 1) begin : g_top
				assign px_in[gr] = pixel_s1;
			end else begin : g_chain
				assign px_in[gr] = line_out[gr+1];
			end

			vcrb_cell #(
				.MAX_KERNEL (MAX_KERNEL),
				.MAX_COLS   (MAX_COLS),
				.COL_W      (COL_W),
				.HAS_LINE   (gr != 0),
				.SUM_W      (SUM_W)
			) u_cell (
				.clk        (clk),
				.en         (en),
				.rd_en      (acc && pix_in),
				.rd_addr    (col_q),
				.wr_en      (en && pix_s1),
				.wr_addr    (col_s1),
				.fwd_s1     (fwd_s1),
				.px_in      (px_in[gr]),
				.coef       (coef_al[gr]),
				.line_out   (line_out[gr]),
				.row_sum_s4 (row_sum[gr])
			);
		end
	endgenerate

	// stage 4: total, stage 5: saturate + ReLU, stage 6: bias
	logic signed [TOT_W-1:0] tot_c;
	logic signed [TOT_W-1:0] total_s5;
	logic [31:0]             relu_s6;
	logic [32:0]             biased;
	out_t                    push_data;

	always_comb begin
		tot_c = '0;
		for (int r = 0; r < MAX_KERNEL; r++) begin
			tot_c = tot_c + {{(TOT_W-SUM_W){row_sum[r][SUM_W-1]}}, row_sum[r]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s5 <= tot_c;
			if (total_s5 < 0) begin
				relu_s6 <= '0;
			end else if (total_s5 > $signed({{(TOT_W-32){1'b0}}, 32'h7fff_ffff})) begin
				relu_s6 <= 32'h7fff_ffff;
			end else begin
				relu_s6 <= total_s5[31:0];
			end
		end
	end

	assign biased = {1'b0, relu_s6} + {bias_q[31], bias_q};

	always_comb begin
		case (biased[32:31])
			2'b01:   push_data.out_value = 32'sh7fff_ffff;
			2'b10:   push_data.out_value = 32'sh8000_0000;
			default: push_data.out_value = $signed(biased[31:0]);
		endcase
		push_data.out_row     = meta_s6.out_row;
		push_data.out_col     = meta_s6.out_col;
		push_data.last_output = meta_s6.last_output;
	end

	vcrb_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && res_s6),
		.push_data (push_data),
		.pop       (out_valid && !out_stall),
		.full      (q_full),
		.valid     (out_valid),
		.data      (out_data)
	);

endmodule

// ===== rtl/core/vcrb_chk.sv =====
// Port-level checks of the convolution block, bound to the top level.
module vcrb_chk import vcrb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// input stalls only with results waiting
	a_stall_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// queue fills only while the output side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without output back-pressure");

endmodule

bind valid_conv2d_relu_bias_top vcrb_chk u_vcrb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
